// File: rtl/amls5_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amls5_pkg
// Shared types, opcodes and match functions for the AML _S5_ scanner.
// ----------------------------------------------------------------------------
package amls5_pkg;

  // Window geometry
  localparam int WIN_DEPTH = 22;
  localparam int CAND_IDX  = 2;

  localparam logic [5:0] WIN_END = 6'd22;

  // AML opcodes and name bytes
  localparam logic [7:0] OP_NAME    = 8'h08;
  localparam logic [7:0] OP_ROOT    = 8'h5C;
  localparam logic [7:0] OP_PACKAGE = 8'h12;
  localparam logic [7:0] OP_ZERO    = 8'h00;
  localparam logic [7:0] OP_ONE     = 8'h01;
  localparam logic [7:0] OP_BYTE    = 8'h0A;
  localparam logic [7:0] OP_WORD    = 8'h0B;
  localparam logic [7:0] OP_DWORD   = 8'h0C;
  localparam logic [7:0] OP_ONES    = 8'hFF;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_S       = 8'h53;
  localparam logic [7:0] CH_5       = 8'h35;
  localparam logic [7:0] MIN_COUNT  = 8'h02;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_table;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [2:0] sleep_type_a;
    logic [2:0] sleep_type_b;
  } out_item_t;

  // Window of recent bytes, element 0 oldest, element WIN_DEPTH-1 newest
  typedef logic [WIN_DEPTH-1:0][7:0] win_t;
  typedef logic [WIN_DEPTH-1:0]      win_valid_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] type_a;
    logic [2:0] type_b;
  } cand_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] next_pos;
    logic [2:0] low3;
  } int_elem_t;

  // Read a window byte; positions past the window read as zero
  function automatic logic [7:0] byte_at(input win_t w, input logic [5:0] p);
    logic [7:0] b;
    b = 8'h00;
    if (p < WIN_END) begin
      b = w[p[4:0]];
    end
    return b;
  endfunction

  // Valid bit of a slot; positions outside the window are never valid
  function automatic logic valid_at(input win_valid_t v, input logic [5:0] p);
    logic r;
    r = 1'b0;
    if (p < WIN_END) begin
      r = v[p[4:0]];
    end
    return r;
  endfunction

  // Decode one integer constant element at position p
  function automatic int_elem_t read_int(input win_t w, input logic [5:0] p);
    int_elem_t  r;
    logic [7:0] op;
    logic [7:0] arg;
    logic [2:0] len;
    logic [2:0] imm;
    logic       known;
    r     = '0;
    op    = byte_at(w, p);
    arg   = byte_at(w, p + 6'd1);
    len   = 3'd1;
    imm   = 3'd0;
    known = 1'b1;
    case (op)
      OP_ZERO:  imm = 3'd0;
      OP_ONE:   imm = 3'd1;
      OP_ONES:  imm = 3'd7;
      OP_BYTE:  len = 3'd2;
      OP_WORD:  len = 3'd3;
      OP_DWORD: len = 3'd5;
      default:  known = 1'b0;
    endcase
    if (known && (p < WIN_END) && ((p + {3'b000, len}) <= WIN_END)) begin
      r.ok       = 1'b1;
      r.next_pos = p + {3'b000, len};
      r.low3     = (len > 3'd1) ? arg[2:0] : imm;
    end
    return r;
  endfunction

  // Check one start position k of the window for a full _S5_ package
  function automatic cand_t try_cand(input win_t w, input win_valid_t v,
                                     input logic [4:0] k);
    cand_t     r;
    logic [5:0] kk;
    logic [5:0] p;
    logic [7:0] lead;
    logic [1:0] extra;
    logic       name_ok;
    logic       named;
    logic       body_ok;
    int_elem_t  ia;
    int_elem_t  ib;
    r       = '0;
    kk      = {1'b0, k};
    name_ok = ((kk + 6'd5) <= WIN_END) && valid_at(v, kk) &&
              (byte_at(w, kk) == CH_UNDER) && (byte_at(w, kk + 6'd1) == CH_S) &&
              (byte_at(w, kk + 6'd2) == CH_5) && (byte_at(w, kk + 6'd3) == CH_UNDER) &&
              (byte_at(w, kk + 6'd4) == OP_PACKAGE);
    // Positions below zero wrap high and read as invalid
    named   = (valid_at(v, kk - 6'd1) && (byte_at(w, kk - 6'd1) == OP_NAME)) ||
              (valid_at(v, kk - 6'd1) && valid_at(v, kk - 6'd2) &&
               (byte_at(w, kk - 6'd1) == OP_ROOT) &&
               (byte_at(w, kk - 6'd2) == OP_NAME));
    p       = kk + 6'd5;
    lead    = byte_at(w, p);
    extra   = lead[7:6];
    body_ok = (p < WIN_END) && ((p + 6'd1 + {4'b0000, extra}) <= WIN_END);
    p       = p + 6'd1 + {4'b0000, extra};
    body_ok = body_ok && (p < WIN_END) && (byte_at(w, p) >= MIN_COUNT);
    p       = p + 6'd1;
    ia      = read_int(w, p);
    ib      = read_int(w, ia.next_pos);
    if (name_ok && named && body_ok && ia.ok && ib.ok) begin
      r.hit    = 1'b1;
      r.type_a = ia.low3;
      r.type_b = ib.low3;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/amls5_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amls5_match
// Checks each start position of the byte window from CAND_IDX up: the decision
// position on its own, and the earliest hit among the later positions for end of table.
// ----------------------------------------------------------------------------
module amls5_match (
  input  wire amls5_pkg::win_t       win,
  input  wire amls5_pkg::win_valid_t win_valid,
  output amls5_pkg::cand_t           head_cand,
  output amls5_pkg::cand_t           tail_cand
);

  amls5_pkg::cand_t cands [amls5_pkg::WIN_DEPTH];

  // Evaluate all start positions from CAND_IDX up in parallel
  for (genvar k = amls5_pkg::CAND_IDX; k < amls5_pkg::WIN_DEPTH; k++) begin : g_cand
    assign cands[k] = amls5_pkg::try_cand(win, win_valid, 5'(k));
  end

  for (genvar k = 0; k < amls5_pkg::CAND_IDX; k++) begin : g_unused
    assign cands[k] = '0;
  end

  assign head_cand = cands[amls5_pkg::CAND_IDX];

  // Pick the earliest hit after the decision position
  always_comb begin
    tail_cand = '0;
    for (int k = amls5_pkg::WIN_DEPTH - 1; k > amls5_pkg::CAND_IDX; k--) begin
      if (cands[k].hit) begin
        tail_cand = cands[k];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/aml_s5_sleep_type_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aml_s5_sleep_type_scanner
// Scans an AML byte stream for Name(_S5_, Package(){a, b, ...}) and reports
// the low three bits of the first two package integers at end of table.
// ----------------------------------------------------------------------------
//  channel | signals                       | carries
//  --------+-------------------------------+----------------------------------
//  input   | in_valid, in_stall, in_data   | one table byte and end marker
//  output  | out_valid, out_stall, out_data| found flag and two sleep types
//
//  One byte per cycle while in_stall is low: a byte shifts into the 22-byte
//  window when accepted, and the window is then checked by fixed compares.
//  out_valid is registered and rises when the held last byte is checked.
//  Input stalls only while a finished result waits on out_stall and the
//  last byte of the next table is waiting to be checked.
//  Reset clears the window valid bits, the match flag and out_valid.
// ----------------------------------------------------------------------------
module aml_s5_sleep_type_scanner (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire amls5_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire                       out_stall,
  output amls5_pkg::out_item_t      out_data
);

  amls5_pkg::win_t       win;
  amls5_pkg::win_valid_t win_valid;
  amls5_pkg::win_valid_t win_valid_next;
  amls5_pkg::win_valid_t win_valid_base;
  logic                  pend_valid;
  logic                  pend_last;
  logic                  match_done;
  logic [2:0]            held_a;
  logic [2:0]            held_b;
  amls5_pkg::cand_t      head_cand;
  amls5_pkg::cand_t      tail_cand;
  amls5_pkg::out_item_t  result;
  logic                  in_take;
  logic                  proc_fire;
  logic                  head_hit;

  amls5_match u_match (
    .win       (win),
    .win_valid (win_valid),
    .head_cand (head_cand),
    .tail_cand (tail_cand)
  );

  // Check the held byte unless a result it produces cannot be stored
  assign proc_fire = pend_valid && !(pend_last && out_valid && out_stall);
  assign in_stall  = pend_valid && !proc_fire;
  assign in_take   = in_valid && !in_stall;
  assign head_hit  = !match_done && head_cand.hit;

  // Build the end-of-table result
  always_comb begin
    result = '0;
    if (match_done) begin
      result.found        = 1'b1;
      result.sleep_type_a = held_a;
      result.sleep_type_b = held_b;
    end else if (head_cand.hit) begin
      result.found        = 1'b1;
      result.sleep_type_a = head_cand.type_a;
      result.sleep_type_b = head_cand.type_b;
    end else if (tail_cand.hit) begin
      result.found        = 1'b1;
      result.sleep_type_a = tail_cand.type_a;
      result.sleep_type_b = tail_cand.type_b;
    end
  end

  // Drop the table at end of table, then shift in any new byte
  always_comb begin
    win_valid_base = win_valid;
    if (proc_fire && pend_last) begin
      win_valid_base = '0;
    end
    win_valid_next = win_valid_base;
    if (in_take) begin
      win_valid_next = {1'b1, win_valid_base[amls5_pkg::WIN_DEPTH-1:1]};
    end
  end

  // Advance the byte window
  always_ff @(posedge clk) begin
    if (in_take) begin
      win <= {in_data.stream_byte, win[amls5_pkg::WIN_DEPTH-1:1]};
    end
  end

  // Track the pending byte and the window valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_last  <= 1'b0;
      win_valid  <= '0;
    end else begin
      win_valid <= win_valid_next;
      if (in_take) begin
        pend_valid <= 1'b1;
        pend_last  <= in_data.end_of_table;
      end else if (proc_fire) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Hold the earliest match until end of table
  always_ff @(posedge clk) begin
    if (rst) begin
      match_done <= 1'b0;
      held_a     <= 3'd0;
      held_b     <= 3'd0;
    end else if (proc_fire && pend_last) begin
      match_done <= 1'b0;
      held_a     <= 3'd0;
      held_b     <= 3'd0;
    end else if (proc_fire && head_hit) begin
      match_done <= 1'b1;
      held_a     <= head_cand.type_a;
      held_b     <= head_cand.type_b;
    end
  end

  // Load the result register; release it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && pend_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && pend_last) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

// File: rtl/amls5_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amls5_checker
// Port-level checks for the AML _S5_ scanner, bound to the top level.
// ----------------------------------------------------------------------------
module amls5_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       in_valid,
  input wire                       in_stall,
  input wire amls5_pkg::in_item_t  in_data,
  input wire                       out_valid,
  input wire                       out_stall,
  input wire amls5_pkg::out_item_t out_data
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // Report zero sleep types when nothing was found
  a_zero_when_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |->
      out_data.sleep_type_a == 3'd0 && out_data.sleep_type_b == 3'd0)
    else $error("sleep types nonzero without a match");

  // A new result must follow an accepted last byte of a table
  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |->
      $past(in_valid && !in_stall && in_data.end_of_table, 2))
    else $error("result without a preceding end of table");

  // Leave reset with no result pending
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind aml_s5_sleep_type_scanner amls5_checker u_amls5_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams AML tables into the _S5_ scanner and compares each end-of-table
// result against a byte-window predictor kept alongside the block.
// ----------------------------------------------------------------------------
module testbench;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  amls5_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  amls5_pkg::out_item_t out_data;

  amls5_pkg::in_item_t  pending_items [$];
  amls5_pkg::out_item_t expected_results [$];
  int                   fail_count = 0;
  int                   results_seen = 0;
  int unsigned          cycle_count = 0;
  int                   hold_left = 0;
  bit                   hold_done = 1'b0;
  amls5_pkg::out_item_t predicted;
  amls5_pkg::out_item_t want;

  // Predictor state: byte window, live bits, match lock and held sleep types
  logic [7:0]                      scan_win [amls5_pkg::WIN_DEPTH] = '{default: 8'h00};
  logic [amls5_pkg::WIN_DEPTH-1:0] scan_live = '0;
  logic                            s5_locked = 1'b0;
  logic [2:0]                      s5_type_a = 3'd0;
  logic [2:0]                      s5_type_b = 3'd0;

  // No idling on either side through this stretch
  wire quiet_stretch = (cycle_count >= 1000) && (cycle_count < 1800);

  aml_s5_sleep_type_scanner dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic bit slot_live(input int k);
    return (k >= 0) && (k < amls5_pkg::WIN_DEPTH) && scan_live[k];
  endfunction

  // Decode one integer constant at pos; fail if unknown or past the window
  function automatic bit decode_int(input int pos, output int nxt,
                                    output logic [2:0] low3);
    int         len;
    logic [7:0] v;
    if (pos >= amls5_pkg::WIN_DEPTH) return 1'b0;
    v = 8'h00;
    case (scan_win[pos])
      amls5_pkg::OP_ZERO:  len = 1;
      amls5_pkg::OP_ONE:   begin v = 8'h01; len = 1; end
      amls5_pkg::OP_ONES:  begin v = 8'hFF; len = 1; end
      amls5_pkg::OP_BYTE:  len = 2;
      amls5_pkg::OP_WORD:  len = 3;
      amls5_pkg::OP_DWORD: len = 5;
      default:             return 1'b0;
    endcase
    if (pos + len > amls5_pkg::WIN_DEPTH) return 1'b0;
    if (len > 1) v = scan_win[pos + 1];
    low3 = v[2:0];
    nxt  = pos + len;
    return 1'b1;
  endfunction

  // Try a full Name(_S5_, Package(){a, b, ...}) starting at window index k
  function automatic bit try_s5_at(input int k);
    int         p;
    int         extra;
    logic [2:0] a;
    logic [2:0] b;
    bit         named;
    if (k + 5 > amls5_pkg::WIN_DEPTH || !slot_live(k)) return 1'b0;
    if (scan_win[k] != amls5_pkg::CH_UNDER || scan_win[k+1] != amls5_pkg::CH_S ||
        scan_win[k+2] != amls5_pkg::CH_5 || scan_win[k+3] != amls5_pkg::CH_UNDER)
      return 1'b0;
    if (scan_win[k+4] != amls5_pkg::OP_PACKAGE) return 1'b0;
    named = (slot_live(k - 1) && scan_win[k-1] == amls5_pkg::OP_NAME) ||
            (slot_live(k - 1) && slot_live(k - 2) &&
             scan_win[k-1] == amls5_pkg::OP_ROOT && scan_win[k-2] == amls5_pkg::OP_NAME);
    if (!named) return 1'b0;
    p = k + 5;
    if (p >= amls5_pkg::WIN_DEPTH) return 1'b0;
    extra = int'(scan_win[p][7:6]);
    if (p + 1 + extra > amls5_pkg::WIN_DEPTH) return 1'b0;
    p = p + 1 + extra;
    if (p >= amls5_pkg::WIN_DEPTH || scan_win[p] < amls5_pkg::MIN_COUNT) return 1'b0;
    p = p + 1;
    if (!decode_int(p, p, a)) return 1'b0;
    if (!decode_int(p, p, b)) return 1'b0;
    s5_type_a = a;
    s5_type_b = b;
    s5_locked = 1'b1;
    return 1'b1;
  endfunction

  // Shift one byte in; on the last byte of a table produce its result
  function automatic bit scan_byte(input amls5_pkg::in_item_t item,
                                   output amls5_pkg::out_item_t res);
    for (int i = 0; i < amls5_pkg::WIN_DEPTH - 1; i++) scan_win[i] = scan_win[i+1];
    scan_win[amls5_pkg::WIN_DEPTH-1] = item.stream_byte;
    scan_live = {1'b1, scan_live[amls5_pkg::WIN_DEPTH-1:1]};
    if (!s5_locked) void'(try_s5_at(amls5_pkg::CAND_IDX));
    if (!item.end_of_table) return 1'b0;
    for (int k = amls5_pkg::CAND_IDX + 1; k < amls5_pkg::WIN_DEPTH && !s5_locked; k++)
      void'(try_s5_at(k));
    res.found        = s5_locked;
    res.sleep_type_a = s5_locked ? s5_type_a : 3'd0;
    res.sleep_type_b = s5_locked ? s5_type_b : 3'd0;
    // Clear for the next table
    scan_win  = '{default: 8'h00};
    scan_live = '0;
    s5_locked = 1'b0;
    s5_type_a = 3'd0;
    s5_type_b = 3'd0;
    return 1'b1;
  endfunction

  // Byte that is often one of the opcodes or name characters
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 11))
      0:       return amls5_pkg::OP_NAME;
      1:       return amls5_pkg::OP_ROOT;
      2:       return amls5_pkg::OP_PACKAGE;
      3:       return amls5_pkg::CH_UNDER;
      4:       return amls5_pkg::CH_S;
      5:       return amls5_pkg::CH_5;
      6:       return amls5_pkg::OP_ZERO;
      7:       return amls5_pkg::OP_ONE;
      8:       return amls5_pkg::OP_ONES;
      9:       return amls5_pkg::OP_BYTE;
      10:      return amls5_pkg::OP_WORD;
      default: return amls5_pkg::OP_DWORD;
    endcase
  endfunction

  task automatic queue_table(input logic [7:0] body [$]);
    amls5_pkg::in_item_t item;
    foreach (body[i]) begin
      item.stream_byte  = body[i];
      item.end_of_table = (i == body.size() - 1);
      pending_items.push_back(item);
    end
  endtask

  // Sender: predict each accepted transaction, then offer the next byte
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (scan_byte(in_data, predicted)) expected_results.push_back(predicted);
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 &&
            (quiet_stretch || $urandom_range(0, 99) >= 10)) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random idling plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 3) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !quiet_stretch && ($urandom_range(0, 99) < 10);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no table end pending");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_data.found);
          fail_count++;
        end
        if (out_data.sleep_type_a !== want.sleep_type_a) begin
          $error("sleep_type_a: expected %0d, got %0d", want.sleep_type_a,
                 out_data.sleep_type_a);
          fail_count++;
        end
        if (out_data.sleep_type_b !== want.sleep_type_b) begin
          $error("sleep_type_b: expected %0d, got %0d", want.sleep_type_b,
                 out_data.sleep_type_b);
          fail_count++;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  initial begin : stimulus
    logic [7:0] tbl [$];
    logic [7:0] lead;
    int         nobj;
    tbl = {};
    // Root prefix, one extra PkgLength byte, DWord then Ones, short table
    queue_table('{amls5_pkg::OP_NAME, amls5_pkg::OP_ROOT, amls5_pkg::CH_UNDER,
                  amls5_pkg::CH_S, amls5_pkg::CH_5, amls5_pkg::CH_UNDER,
                  amls5_pkg::OP_PACKAGE, 8'h40, 8'h00, amls5_pkg::MIN_COUNT,
                  amls5_pkg::OP_DWORD, 8'h0E, 8'h00, 8'h00, 8'h00, amls5_pkg::OP_ONES});
    // One-byte table ending in NameOp, then a name at the very start of the next
    queue_table('{amls5_pkg::OP_NAME});
    queue_table('{amls5_pkg::CH_UNDER, amls5_pkg::CH_S, amls5_pkg::CH_5,
                  amls5_pkg::CH_UNDER, amls5_pkg::OP_PACKAGE, 8'h00,
                  amls5_pkg::MIN_COUNT, amls5_pkg::OP_ONES, amls5_pkg::OP_ZERO});

    // Random tables: noise around mostly well-formed _S5_ objects
    while (pending_items.size() < 2000) begin
      tbl = {};
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6))
        tbl.push_back(noise_byte());
      nobj = ($urandom_range(0, 9) == 0) ? 0 : (($urandom_range(0, 4) == 0) ? 2 : 1);
      repeat (nobj) begin
        case ($urandom_range(0, 7))
          0:       ;
          1, 2:    begin
            tbl.push_back(amls5_pkg::OP_NAME);
            tbl.push_back(amls5_pkg::OP_ROOT);
          end
          3:       tbl.push_back(amls5_pkg::OP_ROOT);
          default: tbl.push_back(amls5_pkg::OP_NAME);
        endcase
        tbl.push_back(amls5_pkg::CH_UNDER);
        tbl.push_back(amls5_pkg::CH_S);
        tbl.push_back(amls5_pkg::CH_5);
        tbl.push_back(amls5_pkg::CH_UNDER);
        tbl.push_back(amls5_pkg::OP_PACKAGE);
        lead = 8'($urandom_range(0, 255));
        tbl.push_back(lead);
        repeat (lead[7:6]) tbl.push_back(8'($urandom_range(0, 255)));
        tbl.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 1))
                                                  : 8'($urandom_range(2, 255)));
        repeat (($urandom_range(0, 3) == 0) ? 3 : 2) begin
          case ($urandom_range(0, 6))
            0: tbl.push_back(amls5_pkg::OP_ZERO);
            1: tbl.push_back(amls5_pkg::OP_ONE);
            2: tbl.push_back(amls5_pkg::OP_ONES);
            3: begin
              tbl.push_back(amls5_pkg::OP_BYTE);
              tbl.push_back(8'($urandom_range(0, 255)));
            end
            4: begin
              tbl.push_back(amls5_pkg::OP_WORD);
              repeat (2) tbl.push_back(8'($urandom_range(0, 255)));
            end
            5: begin
              tbl.push_back(amls5_pkg::OP_DWORD);
              repeat (4) tbl.push_back(8'($urandom_range(0, 255)));
            end
            default: tbl.push_back(noise_byte());
          endcase
        end
        repeat ($urandom_range(0, 5)) tbl.push_back(noise_byte());
      end
      // Corrupt one byte now and then
      if ($urandom_range(0, 5) == 0 && tbl.size() > 0)
        tbl[$urandom_range(0, tbl.size() - 1)] = 8'($urandom_range(0, 255));
      // Cut the table short now and then
      if ($urandom_range(0, 5) == 0 && tbl.size() > 1)
        repeat ($urandom_range(1, tbl.size() - 1)) void'(tbl.pop_back());
      if (tbl.size() == 0) tbl.push_back(noise_byte());
      queue_table(tbl);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain: all bytes accepted, all results seen, then let the pipe settle
    while (pending_items.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS aml_s5_sleep_type_scanner");
    end else begin
      $display("FAIL aml_s5_sleep_type_scanner");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL aml_s5_sleep_type_scanner");
    $finish;
  end

endmodule
